/* design/roi_range_histogram_core_assert.svh */
// Assertion macros shared by the histogram checker.
`ifndef ROI_RANGE_HISTOGRAM_CORE_ASSERT_SVH
`define ROI_RANGE_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define RRH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off during reset.
`define RRH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define RRH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rrh_pkg.sv */
// Package with the constants and types of the region-of-interest histogram.
package rrh_pkg;

    localparam int MAX_BINS         = 16;
    localparam int PIXEL_BITS       = 16;
    localparam int MAX_FRAME_WIDTH  = 1024;
    localparam int MAX_FRAME_HEIGHT = 1024;

    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int NB_W      = 5;
    localparam int FIELD_W   = 16;
    localparam int COUNT_W   = 21;
    localparam int COL_W     = $clog2(MAX_FRAME_WIDTH);
    localparam int ROW_W     = $clog2(MAX_FRAME_HEIGHT);
    localparam int SIZE_W    = 11;
    localparam int OFFS_W    = 10;
    localparam int COORD_W   = 14;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = CFG_IDX_W'(6);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } t_state;

endpackage

/* design/roi_range_histogram_core.sv */
// Region-of-interest histogram: top level with bin table, count memory and readout.
// Usage:
// - Input channel (i_in_valid / o_in_stall): an item with op load writes the
//   inclusive range of one bin; an item with op pixel delivers the next pixel
//   of the frame in raster order. One item is taken per cycle while the
//   block is counting.
// - A pixel inside the window is counted in the lowest active bin whose range
//   holds it. The count memory is read from stage p and the incremented count
//   is written back from stage q; back-to-back hits on one bin are forwarded
//   from the last write.
// - On the final pixel of a frame the input is stalled and the active counts
//   are read out one at a time through the output channel
//   (o_out_valid / i_out_stall); o_last marks the final count. Each count goes
//   through the read pipeline and the output register, and the next count read
//   waits until the previous count has left the output register. The input
//   opens again once the last count read has been issued.
// - A receiver stall holds the output register and delays the next count read.
// - Reset restores the register defaults, empties the pipeline, sets all
//   counts to zero through per-bin valid flags and restarts at row 0, column 0.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data.
module roi_range_histogram_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rrh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [rrh_pkg::BIN_W-1:0]         i_bin_select,
    input  logic [rrh_pkg::FIELD_W-1:0]       i_range_low,
    input  logic [rrh_pkg::FIELD_W-1:0]       i_range_high,
    input  logic [rrh_pkg::FIELD_W-1:0]       i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rrh_pkg::BIN_W-1:0]         o_bin_number,
    output logic [rrh_pkg::COUNT_W-1:0]       o_bin_count,
    output logic                              o_last
);
    import rrh_pkg::*;

    // Configuration registers.
    logic [NB_W-1:0]   r_active_bins;
    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    logic [OFFS_W-1:0] r_window_left;
    logic [OFFS_W-1:0] r_window_top;
    logic [SIZE_W-1:0] r_window_width;
    logic [SIZE_W-1:0] r_window_height;

    // Bin range table, compared in parallel on every pixel.
    logic [PIXEL_BITS-1:0] r_lo [MAX_BINS];
    logic [PIXEL_BITS-1:0] r_hi [MAX_BINS];

    // Count memory and its per-entry valid flags.
    logic [COUNT_W-1:0] r_mem [MAX_BINS];
    logic [COUNT_W-1:0] r_rd_data;
    logic [MAX_BINS-1:0] r_cnt_vld;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    t_state r_state, n_state;
    logic [BIN_W-1:0] r_emit_idx;

    // Pipeline: p issues the memory read, q modifies and writes back.
    logic             r_p_valid, r_p_emit, r_p_last;
    logic [BIN_W-1:0] r_p_bin;
    logic             r_q_valid, r_q_emit, r_q_last;
    logic [BIN_W-1:0] r_q_bin;

    logic               r_wr_valid;
    logic [BIN_W-1:0]   r_wr_bin;
    logic [COUNT_W-1:0] r_wr_data;

    logic               r_out_valid;
    logic [BIN_W-1:0]   r_out_bin;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_last;

    logic [NB_W-1:0]       nb;
    logic [SIZE_W-1:0]     fw, fh;
    logic [PIXEL_BITS-1:0] px;
    logic                  in_win, hit, frame_end, row_end;
    logic [BIN_W-1:0]      hit_bin;
    logic                  in_acc, pix_acc, out_acc;
    logic                  emit_go, emit_last;
    logic                  q_count, q_emit, fwd;
    logic [COUNT_W-1:0]    cur, cnt_next;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign pix_acc = in_acc && (i_op == OP_PIXEL);
    assign out_acc = r_out_valid && !i_out_stall;

    // Bin count and frame sizes outside their useful range are clamped.
    always_comb begin
        if (r_active_bins == '0) begin
            nb = NB_W'(1);
        end else if (r_active_bins > NB_W'(MAX_BINS)) begin
            nb = NB_W'(MAX_BINS);
        end else begin
            nb = r_active_bins;
        end
        if (r_frame_width == '0) begin
            fw = SIZE_W'(1);
        end else if (r_frame_width > SIZE_W'(MAX_FRAME_WIDTH)) begin
            fw = SIZE_W'(MAX_FRAME_WIDTH);
        end else begin
            fw = r_frame_width;
        end
        if (r_frame_height == '0) begin
            fh = SIZE_W'(1);
        end else if (r_frame_height > SIZE_W'(MAX_FRAME_HEIGHT)) begin
            fh = SIZE_W'(MAX_FRAME_HEIGHT);
        end else begin
            fh = r_frame_height;
        end
    end

    assign px = i_pixel[PIXEL_BITS-1:0];

    assign in_win = (COORD_W'(r_col) >= COORD_W'(r_window_left)) &&
                    (COORD_W'(r_col) < COORD_W'(r_window_left) + COORD_W'(r_window_width)) &&
                    (COORD_W'(r_row) >= COORD_W'(r_window_top)) &&
                    (COORD_W'(r_row) < COORD_W'(r_window_top) + COORD_W'(r_window_height));

    assign row_end   = (COORD_W'(r_col) + COORD_W'(1)) >= COORD_W'(fw);
    assign frame_end = row_end && ((COORD_W'(r_row) + COORD_W'(1)) >= COORD_W'(fh));

    // Lowest-index matching bin wins, so the scan runs downwards.
    always_comb begin
        hit     = 1'b0;
        hit_bin = '0;
        for (int i = MAX_BINS - 1; i >= 0; i--) begin
            if ((COORD_W'(i) < COORD_W'(nb)) && (px >= r_lo[i]) && (px <= r_hi[i])) begin
                hit     = 1'b1;
                hit_bin = BIN_W'(i);
            end
        end
    end

    assign emit_last = (COORD_W'(r_emit_idx) + COORD_W'(1)) == COORD_W'(nb);

    // Readout sequencer.
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        emit_go    = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_in_stall = 1'b0;
                if (pix_acc && frame_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                emit_go = !(r_p_valid && r_p_emit) && !(r_q_valid && r_q_emit) &&
                          !r_out_valid;
                if (emit_go && emit_last) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_emit_idx <= '0;
        end else begin
            r_state <= n_state;
            if (emit_go) begin
                r_emit_idx <= emit_last ? '0 : r_emit_idx + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bins   <= NB_W'(16);
            r_frame_width   <= SIZE_W'(1024);
            r_frame_height  <= SIZE_W'(1024);
            r_window_left   <= '0;
            r_window_top    <= '0;
            r_window_width  <= SIZE_W'(1024);
            r_window_height <= SIZE_W'(1024);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ACTIVE_BINS:   r_active_bins   <= i_cfg_data[NB_W-1:0];
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_WINDOW_LEFT:   r_window_left   <= i_cfg_data[OFFS_W-1:0];
                CFG_WINDOW_TOP:    r_window_top    <= i_cfg_data[OFFS_W-1:0];
                CFG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_WINDOW_HEIGHT: r_window_height <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == OP_LOAD)) begin
            r_lo[i_bin_select] <= i_range_low[PIXEL_BITS-1:0];
            r_hi[i_bin_select] <= i_range_high[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            r_p_valid <= (pix_acc && in_win && hit) || emit_go;
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_emit <= emit_go;
        r_p_last <= emit_last;
        r_p_bin  <= emit_go ? r_emit_idx : hit_bin;
        r_q_emit <= r_p_emit;
        r_q_last <= r_p_last;
        r_q_bin  <= r_p_bin;
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_rd_data <= r_mem[r_p_bin];
        end
    end

    assign q_count = r_q_valid && !r_q_emit;
    assign q_emit  = r_q_valid && r_q_emit;

    // A write on the previous edge is not yet in the read data.
    assign fwd      = r_wr_valid && (r_wr_bin == r_q_bin);
    assign cur      = fwd ? r_wr_data : (r_cnt_vld[r_q_bin] ? r_rd_data : '0);
    assign cnt_next = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (q_count) begin
            r_mem[r_q_bin] <= cnt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
            r_cnt_vld  <= '0;
        end else begin
            r_wr_valid <= q_count;
            if (q_emit && r_q_last) begin
                r_cnt_vld <= '0;
            end else if (q_count) begin
                r_cnt_vld[r_q_bin] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_bin  <= r_q_bin;
        r_wr_data <= cnt_next;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (q_emit) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_emit) begin
            r_out_bin   <= r_q_bin;
            r_out_count <= cur;
            r_out_last  <= r_q_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_number = r_out_bin;
    assign o_bin_count  = r_out_count;
    assign o_last       = r_out_last;

endmodule

/* design/rrh_checker.sv */
// Port-level checker for the region-of-interest histogram, bound to the top level.
`include "roi_range_histogram_core_assert.svh"

module rrh_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_wr_en,
    input logic [rrh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [rrh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_op,
    input logic [rrh_pkg::BIN_W-1:0]         i_bin_select,
    input logic [rrh_pkg::FIELD_W-1:0]       i_range_low,
    input logic [rrh_pkg::FIELD_W-1:0]       i_range_high,
    input logic [rrh_pkg::FIELD_W-1:0]       i_pixel,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [rrh_pkg::BIN_W-1:0]         o_bin_number,
    input logic [rrh_pkg::COUNT_W-1:0]       o_bin_count,
    input logic                              o_last
);
    import rrh_pkg::*;

    `RRH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid,
        "output dropped while stalled")

    `RRH_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
        $stable(o_bin_number) && $stable(o_bin_count) && $stable(o_last),
        "output payload changed while stalled")

    // While a count other than the last is on show, the readout still owns the block.
    `RRH_ASSERT_NOW(a_readout_blocks_input, i_clk, i_rst_n, o_out_valid && !o_last,
        o_in_stall, "input open in the middle of a readout")

    `RRH_ASSERT_NEXT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n, !o_out_valid,
        "output valid straight after reset")

endmodule

bind roi_range_histogram_core rrh_checker u_rrh_checker (.*);

/* verif/tb_roi_range_histogram_core.sv */
// Self-checking testbench for the region-of-interest histogram core.
`timescale 1ns / 1ps

module tb_roi_range_histogram_core;
    import rrh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(7);
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ROUNDS = 10;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_idx;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_bin_report;

    typedef struct packed {
        logic               op;
        logic [BIN_W-1:0]   sel;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] px;
        logic               typed;
        logic [COUNT_W-1:0] cnt0;
        logic [COUNT_W-1:0] cnt1;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [BIN_W-1:0]      i_bin_select;
    logic [FIELD_W-1:0]    i_range_low;
    logic [FIELD_W-1:0]    i_range_high;
    logic [FIELD_W-1:0]    i_pixel;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BIN_W-1:0]      o_bin_number;
    logic [COUNT_W-1:0]    o_bin_count;
    logic                  o_last;

    roi_range_histogram_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_bin_select (i_bin_select),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bin_number (o_bin_number),
        .o_bin_count  (o_bin_count),
        .o_last       (o_last)
    );

    // Predicted state of the block.
    logic [NB_W-1:0]    cfg_bins;
    logic [SIZE_W-1:0]  cfg_fw;
    logic [SIZE_W-1:0]  cfg_fh;
    logic [OFFS_W-1:0]  cfg_left;
    logic [OFFS_W-1:0]  cfg_top;
    logic [SIZE_W-1:0]  cfg_ww;
    logic [SIZE_W-1:0]  cfg_wh;
    logic [FIELD_W-1:0] lo_tab [MAX_BINS];
    logic [FIELD_W-1:0] hi_tab [MAX_BINS];
    logic [COUNT_W-1:0] bin_tally [MAX_BINS];
    int                 col_pos;
    int                 row_pos;

    t_bin_report fresh_reports[$];
    t_bin_report awaited_counts[$];
    t_bin_report want;
    int          mismatches;

    bit quiet_end;
    bit hold_req;
    int hold_left;
    int stall_left;
    int flow_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Works out what one accepted transfer does to the histogram state and
    // appends any bin counts that it releases.
    function automatic void histogram_step(logic op, logic [BIN_W-1:0] sel,
                                           logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                                           logic [FIELD_W-1:0] px);
        int nb;
        int fw;
        int fh;
        bit in_window;
        bit placed;
        bit frame_done;
        if (op == OP_LOAD) begin
            lo_tab[sel] = lo;
            hi_tab[sel] = hi;
            return;
        end
        nb = clamp_to(int'(cfg_bins), MAX_BINS);
        fw = clamp_to(int'(cfg_fw), MAX_FRAME_WIDTH);
        fh = clamp_to(int'(cfg_fh), MAX_FRAME_HEIGHT);
        in_window = col_pos >= int'(cfg_left) && col_pos < int'(cfg_left) + int'(cfg_ww) &&
                    row_pos >= int'(cfg_top) && row_pos < int'(cfg_top) + int'(cfg_wh);
        placed = 1'b0;
        if (in_window) begin
            for (int i = 0; i < nb; i++) begin
                if (!placed && px >= lo_tab[i] && px <= hi_tab[i]) begin
                    placed = 1'b1;
                    if (bin_tally[i] != COUNT_MAX) bin_tally[i] = bin_tally[i] + 1'b1;
                end
            end
        end
        frame_done = 1'b0;
        if (col_pos + 1 >= fw) begin
            col_pos = 0;
            if (row_pos + 1 >= fh) begin
                row_pos = 0;
                frame_done = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        if (frame_done) begin
            for (int i = 0; i < nb; i++) begin
                fresh_reports.push_back('{BIN_W'(i), bin_tally[i], i == nb - 1});
            end
            for (int i = 0; i < MAX_BINS; i++) bin_tally[i] = '0;
        end
    endfunction

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet_end) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (flow_left > 0) begin
            flow_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            flow_left = $urandom_range(0, 40);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_counts.size() == 0) begin
                $error("unexpected transfer: bin_number %0d bin_count %0d last %0d",
                       o_bin_number, o_bin_count, o_last);
                mismatches++;
            end else begin
                want = awaited_counts.pop_front();
                if (o_bin_number !== want.bin_idx) begin
                    $error("bin_number: expected %0d, actual %0d", want.bin_idx, o_bin_number);
                    mismatches++;
                end
                if (o_bin_count !== want.count) begin
                    $error("bin_count: expected %0d, actual %0d", want.count, o_bin_count);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [BIN_W-1:0] sel, logic [FIELD_W-1:0] lo,
                             logic [FIELD_W-1:0] hi, logic [FIELD_W-1:0] px, bit typed);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_bin_select <= sel;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_pixel      <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fresh_reports.delete();
        histogram_step(op, sel, lo, hi, px);
        if (!typed) begin
            foreach (fresh_reports[k]) awaited_counts.push_back(fresh_reports[k]);
        end
    endtask

    task automatic hold_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Waits until every count has come out and the pixel pipeline has drained.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_counts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        // Bits above the register's width carry random junk.
        keep = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
        data = CFG_DATA_W'($urandom);
        data = (data & ~keep) | (CFG_DATA_W'(value) & keep);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ACTIVE_BINS:   cfg_bins = data[NB_W-1:0];
            CFG_FRAME_WIDTH:   cfg_fw   = data[SIZE_W-1:0];
            CFG_FRAME_HEIGHT:  cfg_fh   = data[SIZE_W-1:0];
            CFG_WINDOW_LEFT:   cfg_left = data[OFFS_W-1:0];
            CFG_WINDOW_TOP:    cfg_top  = data[OFFS_W-1:0];
            CFG_WINDOW_WIDTH:  cfg_ww   = data[SIZE_W-1:0];
            CFG_WINDOW_HEIGHT: cfg_wh   = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int nb, int fw, int fh, int wl, int wt, int ww, int wh);
        wait_idle();
        write_reg(CFG_ACTIVE_BINS, nb, NB_W);
        write_reg(CFG_FRAME_WIDTH, fw, SIZE_W);
        write_reg(CFG_FRAME_HEIGHT, fh, SIZE_W);
        write_reg(CFG_WINDOW_LEFT, wl, OFFS_W);
        write_reg(CFG_WINDOW_TOP, wt, OFFS_W);
        write_reg(CFG_WINDOW_WIDTH, ww, SIZE_W);
        write_reg(CFG_WINDOW_HEIGHT, wh, SIZE_W);
        write_reg(CFG_SPARE_INDEX, int'($urandom), CFG_DATA_W);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Streams pixels with range loads mixed in; pixel values lean towards
    // the active bin ranges and their edges.
    task automatic feed_pixels(int n_pixels, int load_pct);
        int                 sent;
        int                 b;
        int                 span;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] px;
        sent = 0;
        while (sent < n_pixels) begin
            if (!quiet_end && $urandom_range(0, 7) == 0) hold_input($urandom_range(1, 19));
            lo = FIELD_W'($urandom);
            hi = FIELD_W'($urandom);
            px = FIELD_W'($urandom);
            if ($urandom_range(0, 99) < load_pct) begin
                case ($urandom_range(0, 3))
                    0: hi = (int'(lo) + 3000 > 65535) ? 16'hFFFF
                                                       : lo + FIELD_W'($urandom_range(0, 3000));
                    1: ;
                    2: lo = '0;
                    default: hi = '1;
                endcase
                send_item(OP_LOAD, BIN_W'($urandom_range(0, MAX_BINS - 1)), lo, hi, px, 1'b0);
            end else begin
                b = $urandom_range(0, clamp_to(int'(cfg_bins), MAX_BINS) - 1);
                span = (hi_tab[b] >= lo_tab[b]) ? int'(hi_tab[b] - lo_tab[b]) : 0;
                case ($urandom_range(0, 4))
                    2: px = lo_tab[b] + FIELD_W'($urandom_range(0, span));
                    3: px = $urandom_range(0, 1) ? lo_tab[b] - 1'b1 : hi_tab[b] + 1'b1;
                    4: px = $urandom_range(0, 1) ? lo_tab[b] : hi_tab[b];
                    default: ;
                endcase
                send_item(OP_PIXEL, BIN_W'($urandom), lo, hi, px, 1'b0);
                sent++;
            end
        end
    endtask

    initial begin
        t_stim_row plan[$];
        int        fw;
        int        fh;

        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_op         = OP_LOAD;
        i_bin_select = '0;
        i_range_low  = '0;
        i_range_high = '0;
        i_pixel      = '0;
        i_out_stall  = 1'b0;
        mismatches   = 0;
        quiet_end    = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        flow_left    = 0;

        cfg_bins = NB_W'(16);
        cfg_fw   = SIZE_W'(1024);
        cfg_fh   = SIZE_W'(1024);
        cfg_left = '0;
        cfg_top  = '0;
        cfg_ww   = SIZE_W'(1024);
        cfg_wh   = SIZE_W'(1024);
        for (int i = 0; i < MAX_BINS; i++) begin
            lo_tab[i]    = '0;
            hi_tab[i]    = '0;
            bin_tally[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a 3x2 frame with a two-column window from column 1 and
        // two active bins that overlap, so the lower bin must win.
        set_config(2, 3, 2, 1, 0, 2, 2);
        plan.push_back('{OP_LOAD, 4'd0, 16'd0, 16'd99, 16'h0, 1'b0, 21'd0, 21'd0});
        plan.push_back('{OP_LOAD, 4'd1, 16'd50, 16'hFFFE, 16'h0, 1'b0, 21'd0, 21'd0});
        for (int k = 2; k < MAX_BINS; k++) begin
            plan.push_back('{OP_LOAD, BIN_W'(k), FIELD_W'(k * 4096), FIELD_W'(k * 4096 + 4095),
                             16'h0, 1'b0, 21'd0, 21'd0});
        end
        // Row 0: left of the window, lowest value, value in both bins.
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'd10, 1'b0, 21'd0, 21'd0});
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'd0, 1'b0, 21'd0, 21'd0});
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'd75, 1'b0, 21'd0, 21'd0});
        // Row 1: left of the window, in the window but in no bin, then bin 1.
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'hFFFF, 1'b0, 21'd0, 21'd0});
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'hFFFF, 1'b0, 21'd0, 21'd0});
        plan.push_back('{OP_PIXEL, 4'd0, 16'h0, 16'h0, 16'd100, 1'b1, 21'd2, 21'd1});
        foreach (plan[r]) begin
            send_item(plan[r].op, plan[r].sel, plan[r].lo, plan[r].hi, plan[r].px, plan[r].typed);
            if (plan[r].typed) begin
                awaited_counts.push_back('{BIN_W'(0), plan[r].cnt0, 1'b0});
                awaited_counts.push_back('{BIN_W'(1), plan[r].cnt1, 1'b1});
            end
        end

        // Over-wide frame width; window runs past the frame edge.
        set_config(16, 2047, 1, 20, 0, 1024, 1024);
        feed_pixels(40, 5);
        // Zero bins act as one; zero width acts as one column; tall frame.
        set_config(0, 0, 1024, 0, 20, 1024, 24);
        feed_pixels(40, 5);
        // Bin count above the maximum, single-pixel frames, empty window.
        set_config(31, 0, 0, 1023, 1023, 0, 0);
        feed_pixels(20, 0);
        set_config(17, 5, 4, 0, 0, 1024, 1024);
        feed_pixels(30, 10);
        // Shrinking the frame mid-way ends the current row and frame at once.
        set_config(16, 8, 8, 2, 1, 4, 5);
        feed_pixels(21, 0);
        set_config(16, 3, 2, 2, 1, 4, 5);
        feed_pixels(10, 0);

        for (int p = 0; p < RANDOM_ROUNDS; p++) begin
            if (p == 0) begin
                // Tiny frames while the receiver holds off, so the readout backs up.
                set_config(16, 2, 1, 0, 0, 2, 1);
                hold_req = 1'b1;
            end else begin
                if (p == RANDOM_ROUNDS - 1) quiet_end = 1'b1;
                fw = $urandom_range(0, 8);
                fh = $urandom_range(0, 6);
                set_config($urandom_range(0, 2) == 0 ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16),
                           fw, fh,
                           $urandom_range(0, 5) == 0 ? 1023 : $urandom_range(0, fw + 1),
                           $urandom_range(0, 5) == 0 ? 1023 : $urandom_range(0, fh + 1),
                           $urandom_range(0, 5) == 0 ? 1024 : $urandom_range(0, fw + 1),
                           $urandom_range(0, 5) == 0 ? 1024 : $urandom_range(0, fh + 1));
            end
            feed_pixels($urandom_range(16, 32), 10);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
